// ===== rtl/core/fxlms_pkg.sv =====
package fxlms_pkg;

    // fixed field and arithmetic widths
    localparam int X_W     = 16;
    localparam int Y_W     = 24;
    localparam int W_W     = 32;
    localparam int COEF_W  = 18;
    localparam int ACC_W   = 64;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 66;
    localparam int STEP_W  = 16;
    localparam int MODE_W  = 2;
    localparam int NUM_W   = 40;
    localparam int NORM_W  = 56;
    localparam int DVD_W   = 72;
    localparam int GAIN_W  = 39;
    localparam int GLO_W   = 20;
    localparam int ROM_LEN = 128;
    localparam int ROM_AW  = 7;

    // register indexes
    localparam logic [0:0] REG_STEP_SIZE   = 1'd0;
    localparam logic [0:0] REG_UPDATE_MODE = 1'd1;

    // update modes
    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NLMS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FXLMS = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET    = 16'd3277;
    localparam logic [30:0]       LEAK_Q30      = 31'd1073634450;
    localparam logic [ACC_W-1:0]  NORM_BIAS_RAW = 64'd1074;
    localparam logic [ACC_W-1:0]  NORM_BIAS_FX  = 64'd109951162778;
    localparam logic [W_W-1:0]    W_TAP0_RESET  = 32'd268435;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_rom_t [ROM_LEN];

    // request to the divider
    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [NORM_W-1:0]  divisor;
    } div_req_t;

    // secondary path taps in units of 1e-6
    localparam int PATH_MICRO [ROM_LEN] = '{
        -539527, 103073, -85869, 41707, -36471, -17989, -46357, -62188,
        -41408, 1144, 56746, 50334, 70396, 26260, -13002, -32491,
        45912, 83134, 64953, 17451, -28055, -81927, -64446, 19772,
        61294, 23655, 8050, -247, -20501, -4550, 22577, -226,
        -36727, -32348, -14170, 3504, 18576, 18335, -3477, -11775,
        -7013, 10510, 7916, -2871, -17287, -12419, 1001, 11641,
        17172, 7885, -8855, -8653, 1077, 13083, 11263, 7195,
        3606, -3192, 3925, 6348, 4424, 3187, 1083, -774,
        7062, 2574, 961, 686, -4450, -3796, 982, 2666,
        3605, 1054, -756, -1275, 789, 2338, 1109, 289,
        454, 2579, -6472, -721, -2325, -1583, -1127, 1342,
        2501, 4297, 481, -2161, -929, -562, 1826, -14280,
        3343, -18, 1229, -1417, -1191, 3212, 1508, 694,
        -118, -378, 492, 2244, -2341, 169, -358, 1342,
        1264, 2333, 884, -3596, -5888, -992, -312, 3354,
        -1791, 1387, -638, 1150, 2141, 12, 641, 0
    };

    // Q1.17 taps, rounded half away from zero
    function automatic coef_rom_t build_path_rom();
        coef_rom_t rom;
        longint    m;
        longint    a;
        longint    q;
        for (int j = 0; j < ROM_LEN; j++) begin
            m = longint'(PATH_MICRO[j]);
            a = (m < 0) ? -m : m;
            q = (a * 131072 + 500000) / 1000000;
            rom[j] = COEF_W'((m < 0) ? -q : q);
        end
        return rom;
    endfunction

    localparam coef_rom_t PATH_ROM = build_path_rom();

    // arithmetic shift right with rounding half away from zero
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] v,
        input int unsigned              s
    );
        logic [ACC_W-1:0] half;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        half = ACC_W'(1) << (s - 1);
        mag  = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        q    = (mag + half) >> s;
        return v[ACC_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_to(
        input logic signed [ACC_W-1:0] v,
        input int unsigned              bits
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed((ACC_W'(1) << (bits - 1)) - ACC_W'(1));
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

endpackage

// ===== rtl/core/filtered_x_lms_noise_canceller_top.sv =====
// Leaky normalized filtered-x LMS noise canceller. Each request on the s_ side carries one
// signed Q1.15 microphone sample; one result request on the m_ side returns the sample, the
// anti-noise (adaptive FIR over the raw history, Q4.20) and a simulated error (sample delayed
// PRIMARY_LAG items minus the anti-noise sent through the fixed 128-tap secondary path ROM).
// update_mode 0 keeps the weights, 1 runs leaky NLMS, 2 runs leaky normalized filtered-x LMS.
// All multiplication goes through one shared 33x33 multiplier under a sequencer, with the
// histories kept as ring buffers in block RAM, so the block takes one sample at a time. With
// adaptation on, each item adds a norm sweep, a bit-serial gain division and three multiplier
// products per weight update. The RAM read port per history and the single multiplier set the
// pace. After reset a clearing pass zeroes the histories and loads the reset weights; s_tready
// stays low during it, while configuration writes are taken at any time.
module filtered_x_lms_noise_canceller_top #(
    parameter int ADAPT_TAPS  = 64,
    parameter int PATH_TAPS   = 128,
    parameter int PRIMARY_LAG = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // sample input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,     // [15:0] mic_in
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,     // [15:0] mic_level, [39:16] anti_noise,
                                                        // [63:40] error_sim
    // register writes
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_index,
    input  logic [fxlms_pkg::STEP_W-1:0]   cfg_wr_data
);

    import fxlms_pkg::*;

    // history and ring sizes
    localparam int HIST_LEN = (PATH_TAPS > ADAPT_TAPS) ? PATH_TAPS : ADAPT_TAPS;
    // the sample ring doubles as the primary delay line
    localparam int S_LEN   = (HIST_LEN >= PRIMARY_LAG + 1) ? HIST_LEN : PRIMARY_LAG + 1;
    localparam int S_AW    = $clog2(S_LEN);
    localparam int S_DEPTH = 1 << S_AW;
    localparam int F_AW    = $clog2(ADAPT_TAPS);
    localparam int F_DEPTH = 1 << F_AW;
    localparam int A_AW    = $clog2(PATH_TAPS);
    localparam int A_DEPTH = 1 << A_AW;
    localparam int W_AW    = $clog2(ADAPT_TAPS);
    localparam int CLR_SA  = (S_DEPTH > F_DEPTH) ? S_DEPTH : F_DEPTH;
    localparam int CLR_LEN = (CLR_SA > A_DEPTH) ? CLR_SA : A_DEPTH;
    localparam int CLR_W   = $clog2(CLR_LEN + 1);
    localparam int CNT_W   = $clog2(HIST_LEN + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV1,
        ST_PUSH_F,
        ST_FIR,
        ST_PUSH_A,
        ST_CONV2,
        ST_RD_D,
        ST_GET_D,
        ST_NUM,
        ST_NUM2,
        ST_NORM,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [CLR_W-1:0]         clr_cnt_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               sub_reg;
    logic                     p1_reg;
    logic                     p2_reg;
    logic [S_AW-1:0]          s_head_reg;
    logic [F_AW-1:0]          f_head_reg;
    logic [A_AW-1:0]          a_head_reg;

    logic [STEP_W-1:0]        step_size_reg;
    logic [MODE_W-1:0]        update_mode_reg;

    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;

    // datapath registers
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    coef_t                    coef_reg;
    logic [X_W-1:0]           x_reg;
    logic signed [Y_W-1:0]    xf_reg;
    logic signed [Y_W-1:0]    y_reg;
    logic signed [Y_W-1:0]    e_reg;
    logic signed [ACC_W-1:0]  ysec_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [GAIN_W-1:0]        g_reg;
    logic [Y_W-1:0]           vabs_reg;
    logic                     vneg_reg;
    logic                     tsign_reg;
    logic signed [ACC_W-1:0]  leak_reg;
    logic [ACC_W-1:0]         plo_reg;
    logic [ACC_W-1:0]         p_reg;
    div_req_t                 div_req_reg;

    // ram ports
    logic                     s_we;
    logic [S_AW-1:0]          s_waddr;
    logic [X_W-1:0]           s_wdata;
    logic [S_AW-1:0]          s_raddr;
    logic [X_W-1:0]           s_rdata;
    logic                     f_we;
    logic [F_AW-1:0]          f_waddr;
    logic [Y_W-1:0]           f_wdata;
    logic [F_AW-1:0]          f_raddr;
    logic [Y_W-1:0]           f_rdata;
    logic                     a_we;
    logic [A_AW-1:0]          a_waddr;
    logic [Y_W-1:0]           a_wdata;
    logic [A_AW-1:0]          a_raddr;
    logic [Y_W-1:0]           a_rdata;
    logic                     w_we;
    logic [W_AW-1:0]          w_waddr;
    logic [W_W-1:0]           w_wdata;
    logic [W_AW-1:0]          w_raddr;
    logic [W_W-1:0]           w_rdata;

    logic                     div_done;
    logic [GAIN_W-1:0]        div_quo;

    // combinational helpers
    logic                     in_accept;
    logic                     clearing;
    logic                     fx_mode;
    logic                     adapt_on;
    logic [CNT_W-1:0]         sweep_len;
    logic                     sweep_busy;
    logic [15:0]              cnt_ext;
    coef_t                    rom_coef;
    logic signed [Y_W-1:0]    v_rd;
    logic [Y_W-1:0]           e_abs;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [ACC_W-1:0]         term_mag;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  w_new;
    logic signed [ACC_W-1:0]  d_scaled;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign clearing  = (state_reg == ST_CLEAR);

    // unused mode code behaves as fixed weights
    assign fx_mode  = (update_mode_reg == MODE_FXLMS);
    assign adapt_on = (update_mode_reg == MODE_NLMS) || (update_mode_reg == MODE_FXLMS);

    always_comb begin
        case (state_reg)
            ST_CONV1, ST_CONV2: sweep_len = CNT_W'(PATH_TAPS);
            default:            sweep_len = CNT_W'(ADAPT_TAPS);
        endcase
    end

    assign sweep_busy = (state_reg == ST_CONV1) || (state_reg == ST_FIR) ||
                        (state_reg == ST_CONV2) || (state_reg == ST_NORM);

    // path taps past the stored rom are zero
    assign cnt_ext  = 16'(cnt_reg);
    assign rom_coef = (cnt_ext < 16'(ROM_LEN)) ? PATH_ROM[cnt_ext[ROM_AW-1:0]] : '0;

    // regressor for the update: filtered reference or raw history
    assign v_rd  = fx_mode ? $signed(f_rdata) : Y_W'($signed(s_rdata));
    assign e_abs = e_reg[Y_W-1] ? Y_W'(-e_reg) : Y_W'(e_reg);

    // ring read addresses, newest entry at the head
    assign s_raddr = (state_reg == ST_RD_D) ? s_head_reg - S_AW'(PRIMARY_LAG)
                                            : s_head_reg - S_AW'(cnt_reg);
    assign f_raddr = f_head_reg - F_AW'(cnt_reg);
    assign a_raddr = a_head_reg - A_AW'(cnt_reg);
    assign w_raddr = W_AW'(cnt_reg);

    // ram writes: clearing pass or pushes
    assign s_we    = clearing ? (clr_cnt_reg < CLR_W'(S_DEPTH)) : in_accept;
    assign s_waddr = clearing ? S_AW'(clr_cnt_reg) : s_head_reg + 1'b1;
    assign s_wdata = clearing ? '0 : s_tdata;

    assign f_we    = clearing ? (clr_cnt_reg < CLR_W'(F_DEPTH)) : (state_reg == ST_PUSH_F);
    assign f_waddr = clearing ? F_AW'(clr_cnt_reg) : f_head_reg + 1'b1;
    assign f_wdata = clearing ? '0 : xf_reg;

    assign a_we    = clearing ? (clr_cnt_reg < CLR_W'(A_DEPTH)) : (state_reg == ST_PUSH_A);
    assign a_waddr = clearing ? A_AW'(clr_cnt_reg) : a_head_reg + 1'b1;
    assign a_wdata = clearing ? '0 : y_reg;

    assign w_we    = clearing ? (clr_cnt_reg < CLR_W'(ADAPT_TAPS))
                              : ((state_reg == ST_UPD) && (sub_reg == 2'd1) &&
                                 (cnt_reg != '0));
    assign w_waddr = clearing ? W_AW'(clr_cnt_reg) : W_AW'(cnt_reg - 1'b1);
    assign w_wdata = clearing ? ((clr_cnt_reg == '0) ? W_TAP0_RESET : '0)
                              : w_new[W_W-1:0];

    // weight update: leak plus rounded gain term, saturated to the weight width
    assign term_mag = fx_mode ? ((p_reg + (ACC_W'(1) << 19)) >> 20)
                              : ((p_reg + (ACC_W'(1) << 14)) >> 15);
    assign term     = tsign_reg ? -$signed(term_mag) : $signed(term_mag);
    assign w_new    = sat_to(leak_reg + term, W_W);

    assign d_scaled = ACC_W'($signed(s_rdata)) <<< 5;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CONV1: begin
                mul_a = MUL_W'(coef_reg);
                mul_b = MUL_W'($signed(s_rdata));
            end
            ST_FIR: begin
                mul_a = MUL_W'($signed(w_rdata));
                mul_b = MUL_W'($signed(s_rdata));
            end
            ST_CONV2: begin
                mul_a = MUL_W'(coef_reg);
                mul_b = MUL_W'($signed(a_rdata));
            end
            ST_NUM: begin
                mul_a = MUL_W'(step_size_reg);
                mul_b = MUL_W'(e_abs);
            end
            ST_NORM: begin
                mul_a = MUL_W'(v_rd);
                mul_b = MUL_W'(v_rd);
            end
            ST_UPD: begin
                case (sub_reg)
                    2'd1: begin
                        mul_a = MUL_W'($signed(w_rdata));
                        mul_b = MUL_W'(LEAK_Q30);
                    end
                    2'd2: begin
                        mul_a = MUL_W'(g_reg[GLO_W-1:0]);
                        mul_b = MUL_W'(vabs_reg);
                    end
                    2'd3: begin
                        mul_a = MUL_W'(g_reg[GAIN_W-1:GLO_W]);
                        mul_b = MUL_W'(vabs_reg);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer, config registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            cnt_reg         <= '0;
            sub_reg         <= '0;
            p1_reg          <= 1'b0;
            p2_reg          <= 1'b0;
            s_head_reg      <= '0;
            f_head_reg      <= '0;
            a_head_reg      <= '0;
            step_size_reg   <= STEP_RESET;
            update_mode_reg <= MODE_FIXED;
            m_tvalid_reg    <= 1'b0;
            div_req_reg     <= '0;
        end else begin
            // start is a one-cycle pulse raised when the norm sweep ends
            if (state_reg != ST_NORM) begin
                div_req_reg.start <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_SIZE:   step_size_reg   <= cfg_wr_data;
                    REG_UPDATE_MODE: update_mode_reg <= cfg_wr_data[MODE_W-1:0];
                    default:         step_size_reg   <= step_size_reg;
                endcase
            end

            // the output state refills the result register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            // common sweep pipeline: issue, ram data, product, accumulate
            if (sweep_busy) begin
                if (cnt_reg != sweep_len) begin
                    coef_reg <= rom_coef;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                p1_reg <= (cnt_reg != sweep_len);
                p2_reg <= p1_reg;
                if (p2_reg) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        x_reg      <= s_tdata;
                        s_head_reg <= s_head_reg + 1'b1;
                        cnt_reg    <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_CONV1;
                    end
                end
                ST_CONV1: begin
                    if (cnt_reg == sweep_len && !p1_reg && !p2_reg) begin
                        xf_reg    <= Y_W'(sat_to(round_shift(acc_reg, 12), Y_W));
                        state_reg <= ST_PUSH_F;
                    end
                end
                ST_PUSH_F: begin
                    f_head_reg <= f_head_reg + 1'b1;
                    cnt_reg    <= '0;
                    acc_reg    <= '0;
                    state_reg  <= ST_FIR;
                end
                ST_FIR: begin
                    if (cnt_reg == sweep_len && !p1_reg && !p2_reg) begin
                        y_reg     <= Y_W'(sat_to(round_shift(acc_reg, 23), Y_W));
                        state_reg <= ST_PUSH_A;
                    end
                end
                ST_PUSH_A: begin
                    a_head_reg <= a_head_reg + 1'b1;
                    cnt_reg    <= '0;
                    acc_reg    <= '0;
                    state_reg  <= ST_CONV2;
                end
                ST_CONV2: begin
                    if (cnt_reg == sweep_len && !p1_reg && !p2_reg) begin
                        ysec_reg  <= round_shift(acc_reg, 17);
                        state_reg <= ST_RD_D;
                    end
                end
                ST_RD_D: begin
                    state_reg <= ST_GET_D;
                end
                ST_GET_D: begin
                    e_reg     <= Y_W'(sat_to(d_scaled - ysec_reg, Y_W));
                    state_reg <= adapt_on ? ST_NUM : ST_DONE;
                end
                ST_NUM: begin
                    state_reg <= ST_NUM2;
                end
                ST_NUM2: begin
                    num_reg   <= NUM_W'(prod_reg);
                    cnt_reg   <= '0;
                    acc_reg   <= fx_mode ? $signed(NORM_BIAS_FX) : $signed(NORM_BIAS_RAW);
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    div_req_reg.start <= 1'b0;
                    if (cnt_reg == sweep_len && !p1_reg && !p2_reg) begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.divisor  <= NORM_W'(acc_reg);
                        div_req_reg.dividend <= fx_mode ? {num_reg, 32'd0}
                                                        : DVD_W'({num_reg, 22'd0});
                        state_reg            <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        g_reg     <= div_quo;
                        cnt_reg   <= '0;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    case (sub_reg)
                        2'd0: begin
                            // finish the previous tap's gain product
                            p_reg     <= plo_reg + (ACC_W'(prod_reg) << GLO_W);
                            tsign_reg <= vneg_reg ^ e_reg[Y_W-1];
                            sub_reg   <= 2'd1;
                        end
                        2'd1: begin
                            if (cnt_reg == CNT_W'(ADAPT_TAPS)) begin
                                state_reg <= ST_DONE;
                            end else begin
                                vabs_reg <= v_rd[Y_W-1] ? Y_W'(-v_rd) : Y_W'(v_rd);
                                vneg_reg <= v_rd[Y_W-1];
                                sub_reg  <= 2'd2;
                            end
                        end
                        2'd2: begin
                            leak_reg <= round_shift(ACC_W'(prod_reg), 30);
                            sub_reg  <= 2'd3;
                        end
                        default: begin
                            plo_reg <= ACC_W'(prod_reg);
                            cnt_reg <= cnt_reg + 1'b1;
                            sub_reg <= 2'd0;
                        end
                    endcase
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {e_reg, y_reg, x_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    fxlms_ram #(.WIDTH(X_W), .DEPTH(S_DEPTH)) u_sample_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    fxlms_ram #(.WIDTH(Y_W), .DEPTH(F_DEPTH)) u_filt_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    fxlms_ram #(.WIDTH(Y_W), .DEPTH(A_DEPTH)) u_anti_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    fxlms_ram #(.WIDTH(W_W), .DEPTH(ADAPT_TAPS)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    fxlms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // one sample in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // a result appears only from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the output state");

    // the divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result with no one waiting");

    // weights change only in the clearing pass or the update loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        w_we |-> (state_reg == ST_CLEAR || state_reg == ST_UPD))
        else $error("weight write outside clear or update");

endmodule

// ===== rtl/core/fxlms_ram.sv =====
module fxlms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/fxlms_div.sv =====
module fxlms_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fxlms_pkg::div_req_t             req,
    output logic                            done,
    output logic [fxlms_pkg::GAIN_W-1:0]    quotient
);

    import fxlms_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [NORM_W-1:0] den_reg;
    logic [NORM_W-1:0] rem_reg;
    logic [GAIN_W-1:0] q_reg;
    logic              ovf_reg;

    logic [NORM_W:0]   trial;
    logic              take;

    // restoring step, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign take  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= take ? NORM_W'(trial - {1'b0, den_reg}) : NORM_W'(trial);
            q_reg   <= {q_reg[GAIN_W-2:0], take};
            ovf_reg <= ovf_reg | q_reg[GAIN_W-1];
        end
    end

    // quotient saturates once a bit leaves the gain range
    assign done     = done_reg;
    assign quotient = ovf_reg ? '1 : q_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fxlms_pkg::*;

    localparam int N_ADAPT  = 64;
    localparam int N_PATH   = 128;
    localparam int N_LAG    = 16;
    localparam int STALL_LIMIT = 40000;   // cycles without any accepted request
    localparam int HOLD_CYCLES = 3000;    // long receiver hold-off
    localparam longint LEAK      = 64'sd1073634450;
    localparam longint BIAS_RAW  = 64'sd1074;
    localparam longint BIAS_FX   = 64'sd109951162778;
    localparam longint GAIN_SAT  = (64'sd1 << 39) - 1;
    // mode code with no update rule of its own
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic signed [15:0] level;
        logic signed [23:0] anti;
        logic signed [23:0] err;
    } canceller_out_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic                 cfg_wr_en;
    logic [0:0]           cfg_index;
    logic [STEP_W-1:0]    cfg_wr_data;

    // sample requests waiting to be driven, results the canceller still owes
    logic [15:0]          pending_samples[$];
    canceller_out_t       owed_results[$];

    int      errors;
    int      samples_sent;
    int      results_seen;
    int      mode_samples[4];
    int      idle_cycles;
    bit      calm;          // no random idling on either side
    bit      hold_req;
    int      hold_cnt;
    bit      s_accepted;    // the driven sample was taken at the last rising edge

    // predictor state
    longint  tap_coef[N_PATH];
    longint  tap_w[N_ADAPT];
    longint  raw_hist[N_PATH];
    longint  filt_hist[N_ADAPT];
    longint  anti_hist[N_PATH];
    longint  lag_line[N_LAG];
    int unsigned cur_step;
    int unsigned cur_mode;

    filtered_x_lms_noise_canceller_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // shift right by s, rounding half away from zero
    function automatic longint round_away(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    // floor(num * 2^sh / den) with saturation, one bit per step
    function automatic longint scaled_quotient(longint unsigned num, int sh,
                                               longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q > GAIN_SAT)
            return GAIN_SAT;
        for (int i = 0; i < sh; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
            if (q > GAIN_SAT)
                return GAIN_SAT;
        end
        return longint'(q);
    endfunction

    task automatic clear_canceller_state();
        longint m;
        longint q;
        for (int j = 0; j < N_PATH; j++) begin
            m = longint'(PATH_MICRO[j]);
            q = ((m < 0 ? -m : m) * 131072 + 500000) / 1000000;
            tap_coef[j] = (m < 0) ? -q : q;
            raw_hist[j] = 0;
            anti_hist[j] = 0;
        end
        for (int j = 0; j < N_ADAPT; j++) begin
            tap_w[j] = 0;
            filt_hist[j] = 0;
        end
        tap_w[0] = 268435;
        for (int j = 0; j < N_LAG; j++)
            lag_line[j] = 0;
        cur_step = 3277;
        cur_mode = 32'(MODE_FIXED);
    endtask

    // one sample through the canceller: histories, anti-noise, error, weight update
    function automatic canceller_out_t cancel_sample(logic [15:0] raw);
        canceller_out_t r;
        longint x;
        longint acc;
        longint y;
        longint d;
        longint e;
        longint norm;
        longint g;
        longint v;
        bit     fx;
        x = longint'($signed(raw));
        for (int j = N_PATH - 1; j > 0; j--)
            raw_hist[j] = raw_hist[j-1];
        raw_hist[0] = x;
        acc = 0;
        for (int j = 0; j < N_PATH; j++)
            acc += tap_coef[j] * raw_hist[j];
        for (int j = N_ADAPT - 1; j > 0; j--)
            filt_hist[j] = filt_hist[j-1];
        filt_hist[0] = clip(round_away(acc, 12), 24);
        acc = 0;
        for (int j = 0; j < N_ADAPT; j++)
            acc += tap_w[j] * raw_hist[j];
        y = clip(round_away(acc, 23), 24);
        for (int j = N_PATH - 1; j > 0; j--)
            anti_hist[j] = anti_hist[j-1];
        anti_hist[0] = y;
        d = lag_line[N_LAG-1];
        for (int j = N_LAG - 1; j > 0; j--)
            lag_line[j] = lag_line[j-1];
        lag_line[0] = x;
        acc = 0;
        for (int j = 0; j < N_PATH; j++)
            acc += tap_coef[j] * anti_hist[j];
        e = clip(d * 32 - round_away(acc, 17), 24);
        if (cur_mode == MODE_NLMS || cur_mode == MODE_FXLMS) begin
            fx = (cur_mode == MODE_FXLMS);
            norm = fx ? BIAS_FX : BIAS_RAW;
            for (int j = 0; j < N_ADAPT; j++) begin
                v = fx ? filt_hist[j] : raw_hist[j];
                norm += v * v;
            end
            g = scaled_quotient(longint'(cur_step) * (e < 0 ? -e : e), fx ? 32 : 22, norm);
            if (e < 0)
                g = -g;
            for (int j = 0; j < N_ADAPT; j++) begin
                v = fx ? filt_hist[j] : raw_hist[j];
                tap_w[j] = clip(round_away(tap_w[j] * LEAK, 30)
                                + round_away(g * v, fx ? 20 : 15), 32);
            end
        end
        r.level = raw;
        r.anti = y[23:0];
        r.err = e[23:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // driver: sample requests change at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (s_tvalid && !s_accepted) begin
            // request still waiting, hold it
        end else if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_samples.pop_front();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver readiness: random idling plus the long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    // monitor: predicts on accepted samples, checks accepted results, watchdog
    always @(posedge aclk) begin
        canceller_out_t want;
        s_accepted <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                owed_results.push_back(cancel_sample(s_tdata));
                samples_sent++;
                mode_samples[cur_mode]++;
            end
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("unexpected result %0d: data %h", results_seen, m_tdata);
                end else begin
                    want = owed_results.pop_front();
                    if ($signed(m_tdata[15:0]) != want.level)
                        report_mismatch("mic_level", $signed(m_tdata[15:0]), want.level);
                    if ($signed(m_tdata[39:16]) != want.anti)
                        report_mismatch("anti_noise", $signed(m_tdata[39:16]), want.anti);
                    if ($signed(m_tdata[63:40]) != want.err)
                        report_mismatch("error_sim", $signed(m_tdata[63:40]), want.err);
                end
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no request moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (pending_samples.size() > 0 || s_tvalid || owed_results.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    // register write while the canceller is idle; predictor follows at the same edge
    task automatic write_reg(logic [0:0] idx, logic [STEP_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx == REG_STEP_SIZE)
            cur_step = 32'(val);
        else
            cur_mode = 32'(val[MODE_W-1:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] random_sample(int k);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return 16'($urandom);
        if (kind < 8)
            return 16'($signed($urandom_range(0, 2047)) - 1024);
        // slow triangle with a little noise, closer to real acoustic input
        return 16'(((k % 64) - 32) * 800 + $signed($urandom_range(0, 255)) - 128);
    endfunction

    task automatic run_phase(int n, logic [STEP_W-1:0] step, logic [MODE_W-1:0] mode);
        write_reg(REG_STEP_SIZE, step);
        write_reg(REG_UPDATE_MODE, {{(STEP_W-MODE_W){1'b0}}, mode});
        for (int k = 0; k < n; k++)
            pending_samples.push_back(random_sample(k));
        wait_drained();
    endtask

    initial begin
        errors = 0;
        samples_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        mode_samples = '{default: 0};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        clear_canceller_state();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes and an impulse at the reset settings
        pending_samples = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                            16'h4000, 16'hc000, 16'h5555, 16'haaaa, 16'h7fff,
                            16'h0000, 16'h0000, 16'h0000, 16'h0000};
        wait_drained();
        // huge gain: full-scale jumps after silence, tiny norm
        write_reg(REG_STEP_SIZE, 16'hffff);
        write_reg(REG_UPDATE_MODE, STEP_W'(MODE_NLMS));
        pending_samples = '{16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001};
        wait_drained();
        write_reg(REG_UPDATE_MODE, STEP_W'(MODE_FXLMS));
        pending_samples = '{16'h8000, 16'h7fff, 16'h0000};
        wait_drained();

        // random phases across settings; the receiver stalls hard in the first one
        hold_req = 1'b1;
        run_phase(100, 16'd3277, MODE_NLMS);
        run_phase(100, 16'd3277, MODE_FXLMS);
        calm = 1'b1;
        run_phase(80, 16'hffff, MODE_FXLMS);
        calm = 1'b0;
        run_phase(60, 16'd0, MODE_NLMS);
        run_phase(60, 16'($urandom), MODE_SPARE);
        run_phase(60, 16'($urandom_range(1, 8000)), MODE_FIXED);
        run_phase(120, 16'($urandom_range(100, 20000)), MODE_FXLMS);

        repeat (1000) @(posedge aclk);
        $display("%0d samples, %0d results checked; per mode fixed/nlms/fxlms/unused: %0d %0d %0d %0d",
                 samples_sent, results_seen, mode_samples[0], mode_samples[1],
                 mode_samples[2], mode_samples[3]);
        $display("step sizes 0, 3277 and 65535 used, one long receiver hold-off");
        if (errors == 0 && owed_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, owed_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
